>>> hdl/afsh_pkg.sv
`timescale 1ns / 1ps
package afsh_pkg;

  localparam int WINDOW_BYTES = 6;
  localparam int FILL_W       = $clog2(WINDOW_BYTES);
  localparam int BIDX_W       = $clog2(WINDOW_BYTES);
  localparam int LEN_W        = 13;
  localparam int LIMIT_W      = 16;

  localparam logic [7:0]         HDR_SYNC0      = 8'hFF;
  localparam logic [7:0]         HDR_SYNC1_MASK = 8'hF0;
  localparam logic [7:0]         HDR_LAYER_MASK = 8'h06;
  localparam logic [LEN_W-1:0]   HDR_LEN_MASK   = 13'h1FFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'd32768;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ENT_BYTE,
    ENT_BURST
  } ent_kind_t;

  // bytes[0] is the oldest byte of a burst; a single beat uses bytes[0]
  typedef struct packed {
    ent_kind_t                        kind;
    logic [WINDOW_BYTES-1:0][7:0]     bytes;
  } ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/afsh_front.sv
`timescale 1ns / 1ps
module afsh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [afsh_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  afsh_pkg::q_status_t           q_st,
  output logic                          push,
  output afsh_pkg::ent_t                push_ent
);
  import afsh_pkg::*;

  logic [7:0]         win [WINDOW_BYTES-1];
  logic [7:0]         win_next [WINDOW_BYTES-1];
  logic [FILL_W-1:0]  fill, fill_next;
  logic [LIMIT_W-1:0] pos, pos_next, limit;
  logic [LEN_W-1:0]   rem, rem_next;
  logic               in_frame, in_frame_next;

  logic                         accept;
  logic [WINDOW_BYTES-1:0][7:0] w;
  logic [LEN_W-1:0]             len;
  logic [LEN_W-1:0]             rem_dec;
  logic [LIMIT_W-1:0]           pos_inc;
  logic                         hdr;

  assign in_stall = q_st.full;
  assign accept   = in_valid && !q_st.full;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      w[i] = win[i];
    end
    w[WINDOW_BYTES-1] = data_byte;
  end

  assign len = {w[3][1:0], w[4], w[5][7:5]} & HDR_LEN_MASK;
  assign hdr = (w[0] == HDR_SYNC0)
            && ((w[1] & HDR_SYNC1_MASK) == HDR_SYNC1_MASK)
            && ((w[1] & HDR_LAYER_MASK) == 8'h00)
            && (len >= LEN_W'(WINDOW_BYTES + 1));
  assign rem_dec = rem - LEN_W'(rem != '0);
  assign pos_inc = pos + LIMIT_W'(1);

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      win_next[i] = win[i];
    end
    fill_next      = fill;
    pos_next       = pos;
    rem_next       = rem;
    in_frame_next  = in_frame;
    push           = 1'b0;
    push_ent.kind  = ENT_BYTE;
    push_ent.bytes = '0;
    if (accept) begin
      if (in_frame) begin
        // pass the byte through
        push              = 1'b1;
        push_ent.bytes[0] = data_byte;
        rem_next          = rem_dec;
        if (rem_dec == '0) begin
          in_frame_next = 1'b0;
          fill_next     = '0;
        end
      end else if (fill < FILL_W'(WINDOW_BYTES - 1)) begin
        for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
          if (fill == FILL_W'(i)) win_next[i] = data_byte;
        end
        fill_next = fill + FILL_W'(1);
      end else if (hdr) begin
        push           = 1'b1;
        push_ent.kind  = ENT_BURST;
        push_ent.bytes = w;
        rem_next       = len - LEN_W'(WINDOW_BYTES);
        in_frame_next  = 1'b1;
        pos_next       = '0;
        fill_next      = '0;
      end else begin
        // slide by one byte
        for (int i = 0; i < WINDOW_BYTES - 2; i++) begin
          win_next[i] = win[i+1];
        end
        win_next[WINDOW_BYTES-2] = data_byte;
        if (pos_inc >= limit) begin
          pos_next = '0;
          push     = 1'b1;
        end else begin
          pos_next = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      pos      <= '0;
      rem      <= '0;
      in_frame <= 1'b0;
      limit    <= LIMIT_RESET;
    end else begin
      fill     <= fill_next;
      pos      <= pos_next;
      rem      <= rem_next;
      in_frame <= in_frame_next;
      if (cfg_write) limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      win[i] <= win_next[i];
    end
  end

  a_frame_empty_window: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (fill == '0)) else $error("window not empty inside a frame");
  a_frame_has_bytes: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (rem != '0)) else $error("inside a frame with no bytes left");
  a_burst_sets_frame: assert property (@(posedge clk) disable iff (rst)
    (push && push_ent.kind == ENT_BURST) |=> in_frame)
    else $error("header burst did not enter a frame");

endmodule

>>> hdl/afsh_queue.sv
`timescale 1ns / 1ps
module afsh_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  afsh_pkg::ent_t      push_ent,
  input  logic                pop,
  output afsh_pkg::ent_t      head,
  output afsh_pkg::q_status_t st
);
  import afsh_pkg::*;

  ent_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic [QCNT_W-1:0] count;

  assign st.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign st.empty = (count == '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    st.full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    st.empty |-> !pop) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

>>> hdl/afsh_back.sv
`timescale 1ns / 1ps
module afsh_back (
  input  logic                clk,
  input  logic                rst,
  input  afsh_pkg::ent_t      head,
  input  afsh_pkg::q_status_t q_st,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte
);
  import afsh_pkg::*;

  logic [BIDX_W-1:0] idx;
  logic              beat;
  logic              last;

  assign out_valid = !q_st.empty;
  assign out_byte  = head.bytes[idx];
  assign beat      = out_valid && !out_stall;
  assign last      = (head.kind == ENT_BYTE) || (idx == BIDX_W'(WINDOW_BYTES - 1));
  assign pop       = beat && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (beat) begin
      // advance through a burst, rewind on the last beat of an entry
      idx <= last ? '0 : idx + BIDX_W'(1);
    end
  end

  a_mid_burst: assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> (!q_st.empty && head.kind == ENT_BURST))
    else $error("burst index set without a burst at the head");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= BIDX_W'(WINDOW_BYTES - 1)) else $error("burst index out of range");
  a_burst_step: assert property (@(posedge clk) disable iff (rst)
    (beat && !last) |=> (idx == $past(idx) + BIDX_W'(1)))
    else $error("burst index did not advance");

endmodule

>>> hdl/adts_frame_sync_hunter_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   data_byte [7:0]
// out       output     out_valid / out_stall out_byte [7:0]
// cfg       input      cfg_write             cfg_data [15:0] (search_limit)
//
// Input takes one byte per cycle while the entry queue has room.
// A header sends one six-beat burst entry; output runs one beat per cycle while
// out_stall is low, so the output port sets sustained throughput: one byte per cycle.
// The queue holds four entries; in_stall rises only when it is full.
// rst is synchronous: queue empty, hunting, empty window, limit 32768.
// Output payload comes from queue storage and holds while out_stall is high.
module adts_frame_sync_hunter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [afsh_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte
);
  import afsh_pkg::*;

  q_status_t q_st;
  ent_t      push_ent;
  ent_t      head;
  logic      push;
  logic      pop;

  afsh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_st      (q_st),
    .push      (push),
    .push_ent  (push_ent)
  );

  afsh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .st       (q_st)
  );

  afsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_st      (q_st),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
  );

endmodule
